>>> rtl/arl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_pkg: shared definitions for the address range lookup
// Table geometry, request function codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_BITS    = 10;
  localparam int CNT_BITS    = 11;
  localparam int ADDR_BITS   = 48;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK
  } arl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_load;
    logic accept_lookup;
    logic step;
    logic finish;
  } arl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty_table;
    logic search_more;
    logic out_free;
  } arl_sts_t;

endpackage : arl_pkg
`default_nettype wire

>>> rtl/arl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_if: channel interfaces of the address range lookup
// Request, response and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface arl_req_if import arl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [IDX_BITS-1:0]  entry_index;
  logic [ADDR_BITS-1:0] region_start;
  logic [ADDR_BITS-1:0] region_end;
  logic [ADDR_BITS-1:0] query_address;

  modport source (output valid, func, entry_index, region_start, region_end,
                  query_address, input ready);
  modport sink   (input valid, func, entry_index, region_start, region_end,
                  query_address, output ready);
endinterface : arl_req_if

interface arl_rsp_if import arl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [IDX_BITS-1:0]  match_index;
  logic [ADDR_BITS-1:0] offset;

  modport source (output valid, found, match_index, offset, input ready);
  modport sink   (input valid, found, match_index, offset, output ready);
endinterface : arl_rsp_if

interface arl_cfg_if import arl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : arl_cfg_if
`default_nettype wire

>>> rtl/arl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module arl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : arl_ram
`default_nettype wire

>>> rtl/arl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_ctrl: lookup sequencer
// Accepts requests, steps the binary search and hands off the result.
// ----------------------------------------------------------------------------
module arl_ctrl import arl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_func,
  input  wire arl_sts_t sts,
  output      arl_cmd_t cmd,
  output      logic     req_ready
);

  arl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_func == FUNC_LOOKUP) begin
            cmd.accept_lookup = 1'b1;
            state_next = sts.empty_table ? ST_CHECK : ST_SEARCH;
          end else begin
            cmd.accept_load = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (!sts.search_more) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : arl_ctrl
`default_nettype wire

>>> rtl/arl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_dp: lookup datapath
// Region table RAM, search bounds, range check and response register.
// ----------------------------------------------------------------------------
module arl_dp import arl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire arl_cmd_t             cmd,
  output      arl_sts_t             sts,
  input  wire logic                 cfg_valid,
  input  wire logic [CNT_BITS-1:0]  cfg_data,
  input  wire logic [IDX_BITS-1:0]  entry_index,
  input  wire logic [ADDR_BITS-1:0] region_start,
  input  wire logic [ADDR_BITS-1:0] region_end,
  input  wire logic [ADDR_BITS-1:0] query_address,
  input  wire logic                 rsp_ready,
  output      logic                 rsp_valid,
  output      logic                 found,
  output      logic [IDX_BITS-1:0]  match_index,
  output      logic [ADDR_BITS-1:0] offset
);

  localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

  logic [CNT_BITS-1:0]    entry_count;
  logic [CNT_BITS-1:0]    count_clamp;
  logic [ADDR_BITS-1:0]   query;
  logic [CNT_BITS-1:0]    low, high;
  logic [CNT_BITS-1:0]    low_next, high_next, mid_next, fallback;
  logic [IDX_BITS-1:0]    mid;
  logic                   have;
  logic [2*ADDR_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0]   s_addr, e_addr;
  logic                   lt, eq, more;
  logic                   rd_en;
  logic [IDX_BITS-1:0]    rd_addr;
  logic                   hit;

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid) begin
      entry_count <= cfg_data;
    end
  end

  assign count_clamp = (entry_count > DEPTH_CNT) ? DEPTH_CNT : entry_count;

  // region table: end in the upper half, start in the lower half
  arl_ram #(
    .WIDTH (2*ADDR_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.accept_load),
    .waddr (entry_index),
    .wdata ({region_end, region_start}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign s_addr = rdata[ADDR_BITS-1:0];
  assign e_addr = rdata[2*ADDR_BITS-1:ADDR_BITS];

  // one search step: compare the probed start, narrow the bounds
  always_comb begin
    lt        = s_addr < query;
    eq        = s_addr == query;
    low_next  = lt ? ({1'b0, mid} + CNT_BITS'(1)) : low;
    high_next = (!lt && !eq) ? {1'b0, mid} : high;
    more      = !eq && (low_next < high_next);
    mid_next  = low_next + ((high_next - low_next) >> 1);
    fallback  = high_next - CNT_BITS'(1);
  end

  // table read: first probe at accept, then next probe or fallback slot
  always_comb begin
    rd_en   = cmd.accept_lookup || (cmd.step && !eq);
    rd_addr = '0;
    priority if (cmd.accept_lookup) begin
      rd_addr = IDX_BITS'(count_clamp >> 1);
    end else if (more) begin
      rd_addr = mid_next[IDX_BITS-1:0];
    end else begin
      rd_addr = fallback[IDX_BITS-1:0];
    end
  end

  // search bounds and selected slot
  always_ff @(posedge clk) begin
    if (cmd.accept_lookup) begin
      query <= query_address;
      low   <= '0;
      high  <= count_clamp;
      mid   <= IDX_BITS'(count_clamp >> 1);
      have  <= 1'b0;
    end else if (cmd.step) begin
      low  <= low_next;
      high <= high_next;
      have <= eq || (high_next != '0);
      if (!eq) begin
        mid <= more ? mid_next[IDX_BITS-1:0] : fallback[IDX_BITS-1:0];
      end
    end
  end

  // range check on the selected slot
  assign hit = have && (s_addr <= query) && (query <= e_addr);

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found       <= hit;
      match_index <= hit ? mid : '0;
      offset      <= hit ? (query - s_addr) : '0;
    end
  end

  assign sts.empty_table = (count_clamp == '0);
  assign sts.search_more = more;
  assign sts.out_free    = !rsp_valid || rsp_ready;

endmodule : arl_dp
`default_nettype wire

>>> rtl/address_range_lookup.sv
`default_nettype none
// Load request: written to the table when accepted, no response.
// Lookup request: accept issues the first probe; a search step per table probe
// follows (at most 11 for 1024 entries, one read of the single table RAM read
// port each); a check step waits for the output register, then the next request.
// Reset clears control state and entry_count; the table is not cleared.
// ----------------------------------------------------------------------------
// address_range_lookup: sorted region table with binary-search lookup
// Loads region entries and locates the region that holds a query address.
// ----------------------------------------------------------------------------
module address_range_lookup import arl_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  arl_cfg_if.sink   cfg,
  arl_req_if.sink   req,
  arl_rsp_if.source rsp
);

  arl_cmd_t cmd;
  arl_sts_t sts;

  assign cfg.ready = 1'b1;

  arl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .sts       (sts),
    .cmd       (cmd),
    .req_ready (req.ready)
  );

  arl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.data),
    .entry_index   (req.entry_index),
    .region_start  (req.region_start),
    .region_end    (req.region_end),
    .query_address (req.query_address),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .found         (rsp.found),
    .match_index   (rsp.match_index),
    .offset        (rsp.offset)
  );

endmodule : address_range_lookup
`default_nettype wire

>>> rtl/arl_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arl_checker: port-level checks for the address range lookup
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module arl_checker import arl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic                 req_func,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic                 found,
  input wire logic [IDX_BITS-1:0]  match_index,
  input wire logic [ADDR_BITS-1:0] offset
);

  // hold a response until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before ready");

  // no response straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a miss reports zero index and offset
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> (match_index == '0) && (offset == '0))
    else $error("miss with nonzero index or offset");

  // a load request never produces a response
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func == FUNC_LOAD) && !rsp_valid |=> !rsp_valid)
    else $error("response after load request");

  // a lookup blocks requests in the cycle after it is accepted
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_func == FUNC_LOOKUP) |=> !req_ready)
    else $error("request taken during lookup");

endmodule : arl_checker

bind address_range_lookup arl_checker u_arl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_func    (req.func),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .found       (rsp.found),
  .match_index (rsp.match_index),
  .offset      (rsp.offset)
);
`default_nettype wire
